>>> sv/kpt_pkg.sv
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared key codes, token codes and the result record of the tokenizer.
// ----------------------------------------------------------------------------
package kpt_pkg;

  // Key codes of the keypad. Codes above the end key count as the other key.
  localparam logic [4:0] KEY_DIGIT_LAST = 5'd9;
  localparam logic [4:0] KEY_POINT      = 5'd10;
  localparam logic [4:0] KEY_PLUS       = 5'd11;
  localparam logic [4:0] KEY_MINUS      = 5'd12;
  localparam logic [4:0] KEY_SCI        = 5'd16;
  localparam logic [4:0] KEY_FN_FIRST   = 5'd17;
  localparam logic [4:0] KEY_FN_LAST    = 5'd24;
  localparam logic [4:0] KEY_END        = 5'd26;

  // Token codes.
  localparam logic [3:0] OP_PLUS  = 4'd0;
  localparam logic [3:0] OP_MINUS = 4'd1;
  localparam logic [3:0] FN_NEG   = 4'd8;
  localparam logic [3:0] CODE_NONE = 4'd0;

  localparam int KEY_W  = 5;
  localparam int CODE_W = 4;
  localparam int MANT_W = 48;
  localparam int FRAC_W = 4;
  localparam int POS_W  = 5;

  localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

  // Up to three results can follow from one key.
  localparam int MAX_RES = 3;
  localparam int RES_N_W = 2;

  // Result queue.
  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    KIND_NUMBER   = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_FUNCTION = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_POINT = 2'd1,
    ST_LIMIT = 2'd2
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [CODE_W-1:0]   code;
    logic [MANT_W-1:0]   mant;
    logic [FRAC_W-1:0]   frac;
    logic [POS_W-1:0]    pos;
    status_t             status;
    logic                last;
  } res_t;

endpackage

>>> sv/kpt_engine.sv
// ----------------------------------------------------------------------------
// kpt_engine
// Expression state and the combinational step that turns one key into tokens.
// ----------------------------------------------------------------------------
module kpt_engine import kpt_pkg::*; #(
  parameter int MAX_TOKEN_COUNT = 32,
  parameter int MAX_KEY_COUNT   = 32,
  parameter int MANTISSA_BITS   = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire_i,
  input  logic [KEY_W-1:0]   key_i,
  output res_t               res_o [MAX_RES],
  output logic [RES_N_W-1:0] res_n_o
);

  localparam int TW = $clog2(MAX_TOKEN_COUNT + 2);
  localparam int KW = $clog2(MAX_KEY_COUNT + 1);
  localparam int M  = MANTISSA_BITS;

  logic              held_valid_r, held_valid_nxt;
  kind_t             held_kind_r, held_kind_nxt;
  logic [CODE_W-1:0] held_code_r, held_code_nxt;
  logic [MANT_W-1:0] held_mant_r, held_mant_nxt;
  logic [FRAC_W-1:0] held_frac_r, held_frac_nxt;
  logic [M-1:0]      acc_r, acc_nxt;
  logic [FRAC_W-1:0] acc_frac_r, acc_frac_nxt;
  logic              point_r, point_nxt;
  logic              digits_r, digits_nxt;
  logic [TW-1:0]     tok_r, tok_nxt;
  logic [KW-1:0]     keys_r, keys_nxt;
  logic              drop_r, drop_nxt;

  logic [M+3:0]      acc_wide;
  logic              fits;
  logic [63:0]       acc_ext;
  logic [MANT_W-1:0] num_mant;

  // Ten times the mantissa plus the digit, with headroom to spot overflow.
  assign acc_wide = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (M+4)'(key_i[3:0]);
  assign fits     = (acc_wide[M+3:M] == 4'b0);
  assign acc_ext  = 64'(acc_r);
  assign num_mant = acc_ext[MANT_W-1:0];

  always_comb begin
    logic              hv;
    kind_t             hk;
    logic [CODE_W-1:0] hc;
    logic [MANT_W-1:0] hm;
    logic [FRAC_W-1:0] hf;
    logic [TW-1:0]     t;
    logic [RES_N_W-1:0] n;
    logic              skip;
    logic              clear;

    hv    = held_valid_r;
    hk    = held_kind_r;
    hc    = held_code_r;
    hm    = held_mant_r;
    hf    = held_frac_r;
    t     = tok_r;
    n     = '0;
    skip  = 1'b0;
    clear = 1'b0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_o[i] = '0;
    end

    acc_nxt      = acc_r;
    acc_frac_nxt = acc_frac_r;
    point_nxt    = point_r;
    digits_nxt   = digits_r;
    keys_nxt     = keys_r;
    drop_nxt     = drop_r;

    if (!fire_i) begin
      skip = 1'b1;
    end else if (key_i == KEY_END) begin
      if (!drop_r) begin
        // A pending number becomes a token, then the held token closes the run.
        if (digits_r) begin
          if (hv) begin
            res_o[n] = '{hk, hc, hm, hf, POS_W'(t - 1'b1), ST_OK, 1'b0};
            n = n + 1'b1;
          end
          hv = 1'b1; hk = KIND_NUMBER; hc = CODE_NONE; hm = num_mant; hf = acc_frac_r;
          t  = t + 1'b1;
        end
        if (hv) begin
          res_o[n] = '{hk, hc, hm, hf, POS_W'(t - 1'b1), ST_OK, 1'b1};
        end else begin
          res_o[n] = '{KIND_STATUS, CODE_NONE, '0, '0, '0, ST_OK, 1'b1};
        end
        n = n + 1'b1;
      end
      drop_nxt = 1'b0;
      clear    = 1'b1;
    end else if (drop_r || keys_r >= KW'(MAX_KEY_COUNT)) begin
      skip = 1'b1;
    end else begin
      keys_nxt = keys_r + 1'b1;
      skip     = 1'b1;
      if (key_i <= KEY_DIGIT_LAST) begin
        digits_nxt = 1'b1;
        if (!point_r) begin
          acc_nxt = fits ? acc_wide[M-1:0] : {M{1'b1}};
        end else if (fits && acc_frac_r < FRAC_MAX) begin
          acc_nxt      = acc_wide[M-1:0];
          acc_frac_nxt = acc_frac_r + 1'b1;
        end
      end else if (key_i == KEY_POINT) begin
        if (point_r) begin
          res_o[n] = '{KIND_STATUS, CODE_NONE, '0, '0, '0, ST_POINT, 1'b1};
          n        = n + 1'b1;
          clear    = 1'b1;
          drop_nxt = 1'b1;
        end else begin
          point_nxt = 1'b1;
        end
      end else begin
        skip = 1'b0;
        if (digits_r) begin
          if (hv) begin
            res_o[n] = '{hk, hc, hm, hf, POS_W'(t - 1'b1), ST_OK, 1'b0};
            n = n + 1'b1;
          end
          hv = 1'b1; hk = KIND_NUMBER; hc = CODE_NONE; hm = num_mant; hf = acc_frac_r;
          t  = t + 1'b1;
        end
        acc_nxt      = '0;
        acc_frac_nxt = '0;
        point_nxt    = 1'b0;
        digits_nxt   = 1'b0;

        if (key_i >= KEY_PLUS && key_i <= KEY_SCI) begin
          if (key_i == KEY_MINUS && hv && hk == KIND_OPERATOR && hc == OP_MINUS) begin
            // Minus after a binary minus folds the pair into a plus.
            hc   = OP_PLUS;
            skip = 1'b1;
          end else begin
            if (hv) begin
              res_o[n] = '{hk, hc, hm, hf, POS_W'(t - 1'b1), ST_OK, 1'b0};
              n = n + 1'b1;
            end
            if (key_i == KEY_MINUS &&
                (!hv || hk == KIND_OPERATOR || hk == KIND_FUNCTION)) begin
              hk = KIND_FUNCTION;
              hc = FN_NEG;
            end else begin
              hk = KIND_OPERATOR;
              hc = CODE_W'(key_i - KEY_PLUS);
            end
            hv = 1'b1; hm = '0; hf = '0;
            t  = t + 1'b1;
          end
        end else if (key_i >= KEY_FN_FIRST && key_i <= KEY_FN_LAST) begin
          if (hv) begin
            res_o[n] = '{hk, hc, hm, hf, POS_W'(t - 1'b1), ST_OK, 1'b0};
            n = n + 1'b1;
          end
          hv = 1'b1; hk = KIND_FUNCTION; hc = CODE_W'(key_i - KEY_FN_FIRST);
          hm = '0; hf = '0;
          t  = t + 1'b1;
        end
      end

      if (!skip && t >= TW'(MAX_TOKEN_COUNT)) begin
        res_o[n] = '{KIND_STATUS, CODE_NONE, '0, '0, '0, ST_LIMIT, 1'b1};
        n        = n + 1'b1;
        clear    = 1'b1;
        drop_nxt = 1'b1;
      end
    end

    held_valid_nxt = hv;
    held_kind_nxt  = hk;
    held_code_nxt  = hc;
    held_mant_nxt  = hm;
    held_frac_nxt  = hf;
    tok_nxt        = t;

    if (clear) begin
      held_valid_nxt = 1'b0;
      held_kind_nxt  = KIND_NUMBER;
      held_code_nxt  = '0;
      held_mant_nxt  = '0;
      held_frac_nxt  = '0;
      acc_nxt        = '0;
      acc_frac_nxt   = '0;
      point_nxt      = 1'b0;
      digits_nxt     = 1'b0;
      tok_nxt        = '0;
      keys_nxt       = '0;
    end

    res_n_o = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_kind_r  <= KIND_NUMBER;
      held_code_r  <= '0;
      held_mant_r  <= '0;
      held_frac_r  <= '0;
      acc_r        <= '0;
      acc_frac_r   <= '0;
      point_r      <= 1'b0;
      digits_r     <= 1'b0;
      tok_r        <= '0;
      keys_r       <= '0;
      drop_r       <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_kind_r  <= held_kind_nxt;
      held_code_r  <= held_code_nxt;
      held_mant_r  <= held_mant_nxt;
      held_frac_r  <= held_frac_nxt;
      acc_r        <= acc_nxt;
      acc_frac_r   <= acc_frac_nxt;
      point_r      <= point_nxt;
      digits_r     <= digits_nxt;
      tok_r        <= tok_nxt;
      keys_r       <= keys_nxt;
      drop_r       <= drop_nxt;
    end
  end

`ifndef SYNTH
  // The end key always returns the expression to its reset state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && key_i == KEY_END |=> !held_valid_r && tok_r == '0 && keys_r == '0)
    else $error("expression state not cleared by end key");

  // While keys are being dropped no token may be held.
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> !held_valid_r && tok_r == '0 && !digits_r)
    else $error("token held while dropping keys");

  // The token limit always trips before the count is carried forward.
  a_tok_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tok_r < TW'(MAX_TOKEN_COUNT))
    else $error("token count passed the limit");
`endif

endmodule

>>> sv/kpt_outq.sv
// ----------------------------------------------------------------------------
// kpt_outq
// Four-entry result queue: takes up to three results a cycle, gives one.
// ----------------------------------------------------------------------------
module kpt_outq import kpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  res_t               push_i [MAX_RES],
  input  logic [RES_N_W-1:0] push_n_i,
  input  logic               pop_i,
  output res_t               head_o,
  output logic [QCNT_W-1:0]  cnt_o
);

  res_t              q_r   [QDEPTH];
  res_t              q_nxt [QDEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QCNT_W-1:0] base;

  // Entries leave from slot zero; new entries land just behind the survivors.
  assign base = cnt_r - QCNT_W'(pop_i);

  always_comb begin
    logic [QCNT_W-1:0] off;
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_nxt[i] = pop_i ? q_r[i+1] : q_r[i];
    end
    q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      off = QCNT_W'(i) - base;
      if (QCNT_W'(i) >= base && off < QCNT_W'(push_n_i)) begin
        q_nxt[i] = push_i[off[RES_N_W-1:0]];
      end
    end
    cnt_nxt = base + QCNT_W'(push_n_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign head_o = q_r[0];
  assign cnt_o  = cnt_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} - {3'b0, pop_i} + {2'b0, push_n_i}) <= 4'(QDEPTH))
    else $error("result queue written beyond its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> cnt_r != '0)
    else $error("result taken from an empty queue");
`endif

endmodule

>>> sv/keypad_expression_tokenizer_core.sv
// ----------------------------------------------------------------------------
// keypad_expression_tokenizer_core
// Turns calculator key codes into number, operator and function tokens.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                                | tuser | tlast
//  ---------+-----------+--------------------------------------+-------+------
//  in_      | slave     | key code                             | -     | -
//  out_     | master    | code, mantissa, fraction, pos, status| kind  | last
//
// A key beat is caught in the key register and stepped once the queue has
// room for three results. The step logic writes up to three result beats
// into a four-entry queue, so results reach out_ through the key register
// and the queue registers. The latest token is held back for the minus
// lookahead, so a key's own token normally leaves with the next key's results.
// A key is stepped whenever the queue will have three free places after the
// current output beat leaves, so while out_ is ready keys giving at most one
// result flow at one beat per cycle; a key giving more takes a beat for each.
// Reset (rst_n low, synchronous) empties the queue and clears all expression
// state. A stalled output fills the queue and then holds keys at in_tready.
//
module keypad_expression_tokenizer_core import kpt_pkg::*; #(
  parameter int MAX_TOKEN_COUNT = 32,
  parameter int MAX_KEY_COUNT   = 32,
  parameter int MANTISSA_BITS   = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] key_code, [7:5] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [3:0] token_code, [51:4] mantissa,
                                  // [55:52] fraction_digits,
                                  // [60:56] token_position, [62:61] status,
                                  // [63] zero
  output logic [1:0]  out_tuser,  // [1:0] token_kind
  output logic        out_tlast
);

  // Key register in front of the step logic.
  logic             key_vld_r, key_vld_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  logic               fire;
  logic               pop;
  logic [QCNT_W-1:0]  q_cnt;
  res_t               step_res [MAX_RES];
  logic [RES_N_W-1:0] step_n;
  res_t               head;

  assign pop = out_tvalid && out_tready;

  // Step only when the queue can take the worst case of three results.
  assign fire = key_vld_r &&
                (q_cnt <= QCNT_W'(1) || (q_cnt == QCNT_W'(2) && pop));

  // The key register is free again in the cycle its key is stepped.
  assign in_tready = !key_vld_r || fire;

  always_comb begin
    key_vld_nxt = key_vld_r;
    key_nxt     = key_r;
    if (in_tvalid && in_tready) begin
      key_vld_nxt = 1'b1;
      key_nxt     = in_tdata[KEY_W-1:0];
    end else if (fire) begin
      key_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= 1'b0;
    end else begin
      key_vld_r <= key_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  kpt_engine #(
    .MAX_TOKEN_COUNT (MAX_TOKEN_COUNT),
    .MAX_KEY_COUNT   (MAX_KEY_COUNT),
    .MANTISSA_BITS   (MANTISSA_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire_i  (fire),
    .key_i   (key_r),
    .res_o   (step_res),
    .res_n_o (step_n)
  );

  kpt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (step_res),
    .push_n_i (step_n),
    .pop_i    (pop),
    .head_o   (head),
    .cnt_o    (q_cnt)
  );

  // The head of the queue drives the output beat directly from registers.
  assign out_tvalid = (q_cnt != '0);
  assign out_tdata  = {1'b0, head.status, head.pos, head.frac, head.mant, head.code};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

`ifndef SYNTH
  // Nothing is stepped when no key is waiting.
  a_fire_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> key_vld_r)
    else $error("step without a key");

  // A key refused at the input must find the key register still occupied.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> key_vld_r && !fire)
    else $error("input stalled with a free key register");

  // A waiting key with a nearly empty queue is always stepped.
  a_no_starve: assert property (@(posedge clk) disable iff (!rst_n)
    key_vld_r && q_cnt <= QCNT_W'(1) |-> fire)
    else $error("key held back with room in the queue");
`endif

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keypad expression tokenizer core.
// A queue of key codes feeds a stream driver, and every accepted key is run
// through a bench-side tokenizer that predicts the token beats it causes.
// A monitor compares each result beat with the oldest prediction. Both sides
// idle at random, and the receiver holds off once for a long stretch so that
// the result queue fills and the key input stalls.
// ----------------------------------------------------------------------------
module tb;
  import kpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOKEN_LIMIT  = 32;
  localparam int KEY_LIMIT    = 32;
  localparam int RANDOM_KEYS  = 230;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 150;

  // Key codes that the package does not name.
  localparam logic [4:0] KEY_TIMES  = 5'd13;
  localparam logic [4:0] KEY_DIVIDE = 5'd14;
  localparam logic [4:0] KEY_POWER  = 5'd15;
  localparam logic [4:0] KEY_OTHER  = 5'd25;
  localparam logic [4:0] KEY_ODD    = 5'd31;

  localparam logic [63:0] MANT_ALL = 64'h0000_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  keypad_expression_tokenizer_core #(
    .MAX_TOKEN_COUNT(TOKEN_LIMIT),
    .MAX_KEY_COUNT  (KEY_LIMIT),
    .MANTISSA_BITS  (48)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  logic [4:0] key_q[$];        // keys still to be offered
  res_t       expected_tokens[$];
  int         keys_accepted = 0;
  int         total_keys    = 0;
  int         mismatches    = 0;
  int         cycle_count   = 0;
  int         hold_left     = 0;
  bit         hold_done     = 1'b0;
  logic       quiet;

  // Neither side idles while this window of keys goes through.
  assign quiet = (keys_accepted >= 120) && (keys_accepted < 200);

  // --------------------------------------------------------------------------
  // Bench-side tokenizer: the held token, the number being typed and the
  // expression counters.
  // --------------------------------------------------------------------------
  logic        hold_valid;
  kind_t       hold_kind;
  logic [3:0]  hold_code;
  logic [47:0] hold_mant;
  logic [3:0]  hold_frac;
  logic [63:0] num_acc;
  logic [3:0]  num_frac;
  logic        seen_point;
  logic        seen_digit;
  int          tok_made;
  int          key_count;
  logic        skip_to_end = 1'b0;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic emit_token(kind_t k, logic [3:0] c, logic [47:0] m, logic [3:0] f,
                            logic [4:0] p, status_t s, logic l);
    res_t r;
    r.kind   = k;
    r.code   = c;
    r.mant   = m;
    r.frac   = f;
    r.pos    = p;
    r.status = s;
    r.last   = l;
    expected_tokens.push_back(r);
  endtask

  task automatic clear_expr();
    hold_valid  = 1'b0;
    hold_kind   = KIND_NUMBER;
    hold_code   = CODE_NONE;
    hold_mant   = '0;
    hold_frac   = '0;
    num_acc     = '0;
    num_frac    = '0;
    seen_point  = 1'b0;
    seen_digit  = 1'b0;
    tok_made    = 0;
    key_count   = 0;
  endtask

  task automatic release_held(logic l);
    if (hold_valid)
      emit_token(hold_kind, hold_code, hold_mant, hold_frac, 5'(tok_made - 1), ST_OK, l);
  endtask

  // A new token pushes the previously held one out.
  task automatic hold_token(kind_t k, logic [3:0] c, logic [47:0] m, logic [3:0] f);
    release_held(1'b0);
    hold_valid = 1'b1;
    hold_kind  = k;
    hold_code  = c;
    hold_mant  = m;
    hold_frac  = f;
    tok_made++;
  endtask

  task automatic close_number();
    if (seen_digit)
      hold_token(KIND_NUMBER, CODE_NONE, num_acc[47:0], num_frac);
    num_acc    = '0;
    num_frac   = '0;
    seen_point = 1'b0;
    seen_digit = 1'b0;
  endtask

  task automatic abort_expr(status_t s);
    emit_token(KIND_STATUS, CODE_NONE, '0, '0, '0, s, 1'b1);
    clear_expr();
    skip_to_end = 1'b1;
  endtask

  task automatic tokenize_key(logic [4:0] key);
    logic [63:0] d;
    logic        fits;
    d    = 64'(key);
    fits = num_acc <= (MANT_ALL - d) / 64'd10;
    if (key == KEY_END) begin
      if (skip_to_end) begin
        // An aborted expression ends silently.
        skip_to_end = 1'b0;
        clear_expr();
      end else begin
        close_number();
        if (hold_valid)
          release_held(1'b1);
        else
          emit_token(KIND_STATUS, CODE_NONE, '0, '0, '0, ST_OK, 1'b1);
        clear_expr();
      end
    end else if (!skip_to_end && key_count < KEY_LIMIT) begin
      key_count++;
      if (key <= KEY_DIGIT_LAST) begin
        seen_digit = 1'b1;
        if (!seen_point) begin
          num_acc = fits ? num_acc * 64'd10 + d : MANT_ALL;
        end else if (fits && num_frac < FRAC_MAX) begin
          num_acc  = num_acc * 64'd10 + d;
          num_frac = num_frac + 4'd1;
        end
      end else if (key == KEY_POINT) begin
        if (seen_point)
          abort_expr(ST_POINT);
        else
          seen_point = 1'b1;
      end else begin
        close_number();
        if (key == KEY_MINUS && hold_valid && hold_kind == KIND_OPERATOR &&
            hold_code == OP_MINUS) begin
          // Two minus signs in a row fold into a plus.
          hold_code = OP_PLUS;
        end else begin
          if (key == KEY_MINUS && (!hold_valid || hold_kind == KIND_OPERATOR ||
                                   hold_kind == KIND_FUNCTION))
            hold_token(KIND_FUNCTION, FN_NEG, '0, '0);
          else if (key >= KEY_PLUS && key <= KEY_SCI)
            hold_token(KIND_OPERATOR, 4'(key - KEY_PLUS), '0, '0);
          else if (key >= KEY_FN_FIRST && key <= KEY_FN_LAST)
            hold_token(KIND_FUNCTION, 4'(key - KEY_FN_FIRST), '0, '0);
          if (tok_made >= TOKEN_LIMIT)
            abort_expr(ST_LIMIT);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders.
  // --------------------------------------------------------------------------
  task automatic put_key(logic [4:0] k);
    key_q.push_back(k);
  endtask

  task automatic put_number();
    if ($urandom_range(99) < 10) begin
      put_key(KEY_POINT);
      repeat ($urandom_range(1, 3)) put_key(5'($urandom_range(9)));
    end else begin
      repeat ($urandom_range(1, 4)) put_key(5'($urandom_range(9)));
      if ($urandom_range(99) < 35) begin
        put_key(KEY_POINT);
        repeat ($urandom_range(0, 3)) put_key(5'($urandom_range(9)));
      end
    end
  endtask

  // A well-formed expression, or a broken one ending in a doubled point.
  task automatic put_expression(bit broken);
    int terms;
    terms = $urandom_range(1, 5);
    if ($urandom_range(99) < 30) put_key(KEY_MINUS);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        put_key(5'($urandom_range(KEY_PLUS, KEY_SCI)));
        if ($urandom_range(99) < 20) put_key(KEY_MINUS);
      end
      if ($urandom_range(99) < 25) put_key(5'($urandom_range(KEY_FN_FIRST, KEY_FN_LAST)));
      put_number();
      if ($urandom_range(99) < 5)
        put_key($urandom_range(1) ? KEY_OTHER : 5'($urandom_range(27, 31)));
    end
    if (broken) begin
      put_key(5'($urandom_range(9)));
      put_key(KEY_POINT);
      put_key(5'($urandom_range(9)));
      put_key(KEY_POINT);
      repeat ($urandom_range(0, 3)) put_key(5'($urandom_range(25)));
    end
    put_key(KEY_END);
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 12)) put_key(5'($urandom_range(31)));
    put_key(KEY_END);
  endtask

  // Long digit runs: saturation, fraction truncation and the key limit.
  task automatic put_digit_run();
    int n;
    int point_at;
    int mode;
    n        = $urandom_range(16, 40);
    point_at = $urandom_range(0, n + 8);
    mode     = $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      if (i == point_at) put_key(KEY_POINT);
      case (mode)
        0: begin
          put_key(5'd9);
        end
        1: begin
          put_key(5'($urandom_range(9)));
        end
        default: begin
          put_key(($urandom_range(99) < 90) ? 5'd0 : 5'($urandom_range(9)));
        end
      endcase
    end
    put_key(KEY_END);
  endtask

  // As many tokens as keys up to the token limit, then a few dropped keys.
  task automatic put_token_storm();
    int count;
    count = 0;
    while (count < TOKEN_LIMIT) begin
      if (count <= TOKEN_LIMIT - 2 && $urandom_range(1)) begin
        put_key(5'($urandom_range(9)));
        put_key(5'($urandom_range(KEY_PLUS, KEY_SCI)));
        count += 2;
      end else begin
        put_key(5'($urandom_range(KEY_FN_FIRST, KEY_FN_LAST)));
        count += 1;
      end
    end
    repeat ($urandom_range(0, 5)) put_key(5'($urandom_range(25)));
    put_key(KEY_END);
  endtask

  // --------------------------------------------------------------------------
  // Key driver: predicts on every accepted beat, then offers the next key.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        tokenize_key(in_tdata[4:0]);
        keys_accepted <= keys_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (key_q.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
          in_tdata  <= {3'b000, key_q.pop_front()};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, timed in its own process once enough keys are in.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && keys_accepted >= 60) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind   = kind_t'(out_tuser);
        got.code   = out_tdata[3:0];
        got.mant   = out_tdata[51:4];
        got.frac   = out_tdata[55:52];
        got.pos    = out_tdata[60:56];
        got.status = status_t'(out_tdata[62:61]);
        got.last   = out_tlast;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind=%0d code=%0d mant=%0d",
                                    got.kind, got.code, got.mant));
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind || got.code !== want.code ||
              got.mant !== want.mant || got.frac !== want.frac ||
              got.pos !== want.pos || got.status !== want.status ||
              got.last !== want.last)
            report_mismatch($sformatf(
              "got k%0d c%0d m%0d f%0d p%0d s%0d l%0d, want k%0d c%0d m%0d f%0d p%0d s%0d l%0d",
              got.kind, got.code, got.mant, got.frac, got.pos, got.status, got.last,
              want.kind, want.code, want.mant, want.frac, want.pos, want.status,
              want.last));
        end
      end
      out_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [4:0] opening [0:24];
    int         pick;
    clear_expr();
    // Typed zero, empty expression, lone point, unary and folded minus ending
    // in a doubled point, then every operator with the other keys.
    opening = '{5'd0, KEY_END,
                KEY_END,
                KEY_POINT, KEY_END,
                KEY_MINUS, 5'd7, KEY_POINT, 5'd5, KEY_MINUS, KEY_MINUS,
                KEY_FN_FIRST, KEY_POINT, KEY_POINT, KEY_END,
                5'd9, KEY_PLUS, KEY_TIMES, KEY_DIVIDE, KEY_POWER, KEY_SCI,
                KEY_FN_LAST, KEY_OTHER, KEY_ODD, KEY_END};
    foreach (opening[i]) put_key(opening[i]);
    put_token_storm();
    put_digit_run();
    while (key_q.size() < 25 + RANDOM_KEYS) begin
      pick = $urandom_range(99);
      if (pick < 70)
        put_expression(1'b0);
      else if (pick < 80)
        put_expression(1'b1);
      else if (pick < 90)
        put_noise();
      else if (pick < 95)
        put_token_storm();
      else
        put_digit_run();
    end
    total_keys = key_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (keys_accepted < total_keys) @(negedge clk);
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
